FILE: sv/llw_pkg.sv
// Shared constants, types and a helper function of the link-loss watchdog monitor.
`timescale 1ns / 1ps
package llw_pkg;

    localparam int DEVICES   = 8;
    localparam int IDX_W     = 3;
    localparam int TICK_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int PRIO_W    = 4;
    localparam int TOP_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [TOP_W-1:0] NONE_DEV = TOP_W'(DEVICES);

    localparam logic CMD_SCAN    = 1'b0;
    localparam logic CMD_RECEIVE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_LO = 3'd0,
        CFG_OFF_HI = 3'd1,
        CFG_SET_LO = 3'd2,
        CFG_SET_HI = 3'd3,
        CFG_PRIO   = 3'd4,
        CFG_ENABLE = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic             rx;
        logic             scan_start;
        logic             step;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Picks the 16-bit limit of one device out of a low/high pair of packed words.
    function automatic logic [LIMIT_W-1:0] field16(input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi,
                                                   input logic [IDX_W-1:0] d);
        logic [CFG_W-1:0] w;
        w = d[2] ? hi : lo;
        return w[{d[1:0], 4'b0000} +: LIMIT_W];
    endfunction

endpackage

FILE: sv/llw_ctrl.sv
// Controller of the link-loss watchdog monitor: input handshake and scan sequencing.
`timescale 1ns / 1ps
module llw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_command,
    output logic                o_stall,
    input  llw_pkg::t_dp_status i_status,
    output llw_pkg::t_dp_cmd    o_cmd
);
    import llw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             step;
    logic             last;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign step   = (r_state == ST_SCAN) && i_status.out_free;
    assign last   = ({1'b0, r_idx} == (IDX_W + 1)'(DEVICES - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_SCAN)) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_cmd.rx         = accept && (i_command == CMD_RECEIVE);
    assign o_cmd.scan_start = accept && (i_command == CMD_SCAN);
    assign o_cmd.step       = step;
    assign o_cmd.last       = last;
    assign o_cmd.idx        = r_idx;

endmodule

FILE: sv/llw_dp.sv
// Datapath of the link-loss watchdog monitor: device state, configuration and result register.
`timescale 1ns / 1ps
module llw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  llw_pkg::t_dp_cmd              i_cmd,
    output llw_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_we,
    input  logic [llw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [llw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [llw_pkg::IDX_W-1:0]     i_device,
    input  logic [llw_pkg::TICK_W-1:0]    i_now,
    input  logic                          i_data_bad,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [llw_pkg::IDX_W-1:0]     o_unit,
    output logic                          o_error_present,
    output logic                          o_lost,
    output logic                          o_bad_data,
    output logic                          o_recover_request,
    output logic [llw_pkg::TICK_W-1:0]    o_arrival_interval,
    output logic [llw_pkg::TICK_W-1:0]    o_lost_since,
    output logic                          o_any_lost,
    output logic [llw_pkg::TOP_W-1:0]     o_top_device,
    output logic                          o_last
);
    import llw_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]   r_off_lo, r_off_hi, r_set_lo, r_set_hi;
    logic [31:0]        r_prio;
    logic [DEVICES-1:0] r_enable;

    // Per-device state.
    logic [TICK_W-1:0] r_newest    [DEVICES];
    logic [TICK_W-1:0] r_previous  [DEVICES];
    logic [TICK_W-1:0] r_reconnect [DEVICES];
    logic [TICK_W-1:0] r_offtime   [DEVICES];
    logic [TICK_W-1:0] r_interval  [DEVICES];
    logic [DEVICES-1:0] r_lost, r_err, r_bad;

    // Scan time and running summary.
    logic [TICK_W-1:0] r_now;
    logic              r_any;
    logic [PRIO_W-1:0] r_best;
    logic [TOP_W-1:0]  r_top;

    logic              r_out_valid;

    logic [IDX_W-1:0]   a;
    logic               in_range;
    logic [TICK_W-1:0]  newest_rd, previous_rd;
    logic [LIMIT_W-1:0] off16, set16;
    logic [PRIO_W-1:0]  pr;
    logic               en;
    logic [TICK_W-1:0]  silence, since_rc;
    logic               offline, settling, healthy;
    logic               n_lost, n_err;
    logic [TICK_W-1:0]  n_offtime, n_interval;
    logic               n_any;
    logic [PRIO_W-1:0]  n_best;
    logic [TOP_W-1:0]   n_top;

    assign a           = i_cmd.step ? i_cmd.idx : i_device;
    assign in_range    = ({1'b0, i_device} < (IDX_W + 1)'(DEVICES));
    assign newest_rd   = r_newest[a];
    assign previous_rd = r_previous[a];
    assign off16       = field16(r_off_lo, r_off_hi, a);
    assign set16       = field16(r_set_lo, r_set_hi, a);
    assign pr          = r_prio[{a, 2'b00} +: PRIO_W];
    assign en          = r_enable[a];
    assign silence     = r_now - newest_rd;
    assign since_rc    = r_now - r_reconnect[a];
    assign offline     = en && (silence > {{(TICK_W - LIMIT_W){1'b0}}, off16});
    assign settling    = en && !offline && (since_rc < {{(TICK_W - LIMIT_W){1'b0}}, set16});
    assign healthy     = en && !offline && !settling;

    always_comb begin
        n_lost     = r_lost[a];
        n_err      = r_err[a];
        n_offtime  = r_offtime[a];
        n_interval = r_interval[a];
        if (offline) begin
            // An error already flagged keeps the original loss time.
            if (!r_err[a]) begin
                n_lost    = 1'b1;
                n_err     = 1'b1;
                n_offtime = r_now;
            end
        end else if (settling) begin
            n_lost = 1'b0;
            n_err  = 1'b1;
        end else if (healthy) begin
            n_lost = 1'b0;
            n_err  = r_bad[a];
            if (newest_rd > previous_rd) begin
                n_interval = newest_rd - previous_rd;
            end
        end
    end

    always_comb begin
        n_any  = r_any || offline;
        n_best = r_best;
        n_top  = r_top;
        if (offline && (pr > r_best)) begin
            n_best = pr;
            n_top  = {1'b0, a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_lo <= '0;
            r_off_hi <= '0;
            r_set_lo <= '0;
            r_set_hi <= '0;
            r_prio   <= '0;
            r_enable <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_OFF_LO: r_off_lo <= i_cfg_data;
                CFG_OFF_HI: r_off_hi <= i_cfg_data;
                CFG_SET_LO: r_set_lo <= i_cfg_data;
                CFG_SET_HI: r_set_hi <= i_cfg_data;
                CFG_PRIO:   r_prio   <= i_cfg_data[31:0];
                CFG_ENABLE: r_enable <= i_cfg_data[DEVICES-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEVICES; i++) begin
                r_newest[i]    <= '0;
                r_previous[i]  <= '0;
                r_reconnect[i] <= '0;
                r_offtime[i]   <= '0;
                r_interval[i]  <= '0;
            end
            r_lost <= '1;
            r_err  <= '1;
            r_bad  <= '1;
        end else if (i_cmd.rx && in_range) begin
            r_previous[a] <= newest_rd;
            r_newest[a]   <= i_now;
            if (r_lost[a]) begin
                r_lost[a]      <= 1'b0;
                r_reconnect[a] <= i_now;
            end
            r_bad[a] <= i_data_bad;
            if (i_data_bad) begin
                r_err[a] <= 1'b1;
            end
        end else if (i_cmd.step) begin
            r_lost[a]     <= n_lost;
            r_err[a]      <= n_err;
            r_offtime[a]  <= n_offtime;
            r_interval[a] <= n_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_now <= i_now;
        end
        if (!i_rst_n) begin
            r_any  <= 1'b0;
            r_best <= '0;
            r_top  <= NONE_DEV;
        end else if (i_cmd.scan_start) begin
            r_any  <= 1'b0;
            r_best <= '0;
            r_top  <= NONE_DEV;
        end else if (i_cmd.step) begin
            r_any  <= n_any;
            r_best <= n_best;
            r_top  <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.step) begin
            o_unit             <= a;
            o_error_present    <= n_err;
            o_lost             <= n_lost;
            o_bad_data         <= r_bad[a];
            o_recover_request  <= offline;
            o_arrival_interval <= n_interval;
            o_lost_since       <= n_offtime;
            o_any_lost         <= i_cmd.last ? n_any : 1'b0;
            o_top_device       <= i_cmd.last ? n_top : NONE_DEV;
            o_last             <= i_cmd.last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status.out_free = !r_out_valid || !i_stall;

endmodule

FILE: sv/link_loss_watchdog_monitor.sv
// Top level of the link-loss watchdog monitor: controller, datapath and checks.
// A receive item updates its device at the edge that accepts it and gives no result,
// and the next item can be taken in the following cycle. A scan item moves the controller
// into its scan state and registers one result per device, eight in all, one per cycle
// while the output is not stalled. The input stays stalled until the last result is
// registered. Reset is synchronous, active low: configuration and arrival times clear to
// zero, and every device starts lost, in error and with bad data.
`timescale 1ns / 1ps
module link_loss_watchdog_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [llw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [llw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [llw_pkg::IDX_W-1:0]     i_device,
    input  logic [llw_pkg::TICK_W-1:0]    i_now,
    input  logic                          i_data_bad,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [llw_pkg::IDX_W-1:0]     o_unit,
    output logic                          o_error_present,
    output logic                          o_lost,
    output logic                          o_bad_data,
    output logic                          o_recover_request,
    output logic [llw_pkg::TICK_W-1:0]    o_arrival_interval,
    output logic [llw_pkg::TICK_W-1:0]    o_lost_since,
    output logic                          o_any_lost,
    output logic [llw_pkg::TOP_W-1:0]     o_top_device,
    output logic                          o_last
);
    import llw_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller owns the input handshake and walks the device index during a scan.
    llw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    // The datapath holds the per-device timers and flags, the configuration and the
    // output register, which lets a receive item in while a result waits to be taken.
    llw_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_device           (i_device),
        .i_now              (i_now),
        .i_data_bad         (i_data_bad),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_unit             (o_unit),
        .o_error_present    (o_error_present),
        .o_lost             (o_lost),
        .o_bad_data         (o_bad_data),
        .o_recover_request  (o_recover_request),
        .o_arrival_interval (o_arrival_interval),
        .o_lost_since       (o_lost_since),
        .o_any_lost         (o_any_lost),
        .o_top_device       (o_top_device),
        .o_last             (o_last)
    );

    // The final result of a scan always reports the highest device index.
    a_last_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_unit == IDX_W'(DEVICES - 1))
        else $error("last result does not report the final device");

    // The summary fields stay at their idle values on every result but the last.
    a_summary_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_any_lost && o_top_device == NONE_DEV)
        else $error("summary fields set on a non-final result");

    // A named top device implies that some device is offline.
    a_top_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_top_device != NONE_DEV |-> o_any_lost)
        else $error("top device named without any device offline");

    // An offline device is always reported with its error flag set.
    a_recover_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_recover_request |-> o_error_present)
        else $error("recovery requested without error present");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench: random and directed receive/scan items, checked per field by a model.
`timescale 1ns / 1ps
module testbench;
    import llw_pkg::*;

    // Register indexes past the end of the map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int SETTLE_CYCLES  = 4;
    localparam int FINAL_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 70;

    typedef struct packed {
        logic [IDX_W-1:0]  unit;
        logic              error_present;
        logic              lost;
        logic              bad_data;
        logic              recover_request;
        logic [TICK_W-1:0] arrival_interval;
        logic [TICK_W-1:0] lost_since;
        logic              any_lost;
        logic [TOP_W-1:0]  top_device;
        logic              last;
    } t_link_report;

    // Tracks every device the way the monitor should, and holds the reports that
    // each accepted scan item is owed.
    class link_status_scoreboard;
        logic [CFG_W-1:0]  offline_lo, offline_hi, settle_lo, settle_hi;
        logic [31:0]       priorities;
        logic [DEVICES-1:0] enabled;
        logic [TICK_W-1:0] newest[DEVICES];
        logic [TICK_W-1:0] previous[DEVICES];
        logic [TICK_W-1:0] reconnect[DEVICES];
        logic [TICK_W-1:0] lost_at[DEVICES];
        logic [TICK_W-1:0] interval[DEVICES];
        logic              lost[DEVICES];
        logic              in_error[DEVICES];
        logic              bad_flag[DEVICES];
        t_link_report      expected_reports[$];
        int                failures;

        function new();
            offline_lo = '0;
            offline_hi = '0;
            settle_lo  = '0;
            settle_hi  = '0;
            priorities = '0;
            enabled    = '0;
            failures   = 0;
            for (int d = 0; d < DEVICES; d++) begin
                newest[d]    = '0;
                previous[d]  = '0;
                reconnect[d] = '0;
                lost_at[d]   = '0;
                interval[d]  = '0;
                lost[d]      = 1'b1;
                in_error[d]  = 1'b1;
                bad_flag[d]  = 1'b1;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_OFF_LO: offline_lo = data;
                CFG_OFF_HI: offline_hi = data;
                CFG_SET_LO: settle_lo  = data;
                CFG_SET_HI: settle_hi  = data;
                CFG_PRIO:   priorities = data[31:0];
                CFG_ENABLE: enabled    = data[DEVICES-1:0];
                default: ;
            endcase
        endfunction

        function logic [LIMIT_W-1:0] limit_of(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                                              int d);
            logic [CFG_W-1:0] word;
            word = (d >= 4) ? hi : lo;
            return word[(d % 4) * LIMIT_W +: LIMIT_W];
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        // A receive item only updates its device; a scan item walks all devices
        // and queues one report per device.
        function void record_item(logic cmd, logic [IDX_W-1:0] dev, logic [TICK_W-1:0] now,
                                  logic bad);
            t_link_report      rep[DEVICES];
            logic [PRIO_W-1:0] best;
            logic [PRIO_W-1:0] prio;
            logic [TOP_W-1:0]  top;
            logic              any;
            logic              recover;
            logic [TICK_W-1:0] silence;
            logic [TICK_W-1:0] since_reconnect;
            if (cmd == CMD_RECEIVE) begin
                previous[dev] = newest[dev];
                newest[dev]   = now;
                if (lost[dev]) begin
                    lost[dev]      = 1'b0;
                    reconnect[dev] = now;
                end
                if (bad) begin
                    in_error[dev] = 1'b1;
                    bad_flag[dev] = 1'b1;
                end else begin
                    bad_flag[dev] = 1'b0;
                end
                return;
            end
            best = '0;
            top  = NONE_DEV;
            any  = 1'b0;
            for (int d = 0; d < DEVICES; d++) begin
                recover = 1'b0;
                if (enabled[d]) begin
                    prio            = priorities[d * PRIO_W +: PRIO_W];
                    silence         = now - newest[d];
                    since_reconnect = now - reconnect[d];
                    if (silence > TICK_W'(limit_of(offline_lo, offline_hi, d))) begin
                        // A device already in error keeps its old offline stamp.
                        if (!in_error[d]) begin
                            lost[d]     = 1'b1;
                            in_error[d] = 1'b1;
                            lost_at[d]  = now;
                        end
                        // Strictly greater wins, so priority zero never ranks.
                        if (prio > best) begin
                            best = prio;
                            top  = TOP_W'(d);
                        end
                        any     = 1'b1;
                        recover = 1'b1;
                    end else if (since_reconnect <
                                 TICK_W'(limit_of(settle_lo, settle_hi, d))) begin
                        lost[d]     = 1'b0;
                        in_error[d] = 1'b1;
                    end else begin
                        lost[d]     = 1'b0;
                        in_error[d] = bad_flag[d];
                        if (newest[d] > previous[d]) begin
                            interval[d] = newest[d] - previous[d];
                        end
                    end
                end
                rep[d].unit             = IDX_W'(d);
                rep[d].error_present    = in_error[d];
                rep[d].lost             = lost[d];
                rep[d].bad_data         = bad_flag[d];
                rep[d].recover_request  = recover;
                rep[d].arrival_interval = interval[d];
                rep[d].lost_since       = lost_at[d];
                rep[d].any_lost         = 1'b0;
                rep[d].top_device       = NONE_DEV;
                rep[d].last             = 1'b0;
            end
            rep[DEVICES-1].any_lost   = any;
            rep[DEVICES-1].top_device = top;
            rep[DEVICES-1].last       = 1'b1;
            for (int d = 0; d < DEVICES; d++) begin
                expected_reports.push_back(rep[d]);
            end
        endfunction

        function void compare(string field, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_report(t_link_report got);
            t_link_report want;
            if (expected_reports.size() == 0) begin
                $error("report for unit %0d arrived with none expected", got.unit);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare("unit", want.unit, got.unit);
            compare("error_present", want.error_present, got.error_present);
            compare("lost", want.lost, got.lost);
            compare("bad_data", want.bad_data, got.bad_data);
            compare("recover_request", want.recover_request, got.recover_request);
            compare("arrival_interval", want.arrival_interval, got.arrival_interval);
            compare("lost_since", want.lost_since, got.lost_since);
            compare("any_lost", want.any_lost, got.any_lost);
            compare("top_device", want.top_device, got.top_device);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  i_command   = CMD_SCAN;
    logic [IDX_W-1:0]      i_device    = '0;
    logic [TICK_W-1:0]     i_now       = '0;
    logic                  i_data_bad  = 1'b0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [IDX_W-1:0]      o_unit;
    logic                  o_error_present;
    logic                  o_lost;
    logic                  o_bad_data;
    logic                  o_recover_request;
    logic [TICK_W-1:0]     o_arrival_interval;
    logic [TICK_W-1:0]     o_lost_since;
    logic                  o_any_lost;
    logic [TOP_W-1:0]      o_top_device;
    logic                  o_last;

    link_status_scoreboard status_board = new;

    // Idle controls, changed per phase by the stimulus process.
    bit sender_idles = 1'b1;
    bit stall_quiet  = 1'b0;
    int stall_hold   = 0;
    int stall_pick   = 0;
    int idle_cycles  = 0;
    t_link_report observed;

    link_loss_watchdog_monitor u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_device           (i_device),
        .i_now              (i_now),
        .i_data_bad         (i_data_bad),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_unit             (o_unit),
        .o_error_present    (o_error_present),
        .o_lost             (o_lost),
        .o_bad_data         (o_bad_data),
        .o_recover_request  (o_recover_request),
        .o_arrival_interval (o_arrival_interval),
        .o_lost_since       (o_lost_since),
        .o_any_lost         (o_any_lost),
        .o_top_device       (o_top_device),
        .o_last             (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Output back-pressure: mostly short bursts of stall, now and then a long one,
    // and no new ones while stall_quiet is set.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold--;
        end else if (stall_quiet) begin
            i_stall <= 1'b0;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                i_stall    <= 1'b0;
                stall_hold = $urandom_range(0, 3);
            end else if (stall_pick < 94) begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(10, 40);
            end
        end
    end

    // Every report taken by the bench is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            observed.unit             = o_unit;
            observed.error_present    = o_error_present;
            observed.lost             = o_lost;
            observed.bad_data         = o_bad_data;
            observed.recover_request  = o_recover_request;
            observed.arrival_interval = o_arrival_interval;
            observed.lost_since       = o_lost_since;
            observed.any_lost         = o_any_lost;
            observed.top_device       = o_top_device;
            observed.last             = o_last;
            status_board.check_report(observed);
        end
    end

    // The run is stuck if nothing moves on either channel or the register port.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one item and holds it until the block takes it.
    task automatic send_item(logic cmd, logic [IDX_W-1:0] dev, logic [TICK_W-1:0] now,
                             logic bad);
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_device   <= dev;
        i_now      <= now;
        i_data_bad <= bad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        status_board.record_item(cmd, dev, now, bad);
    endtask

    task automatic random_gap();
        int pick;
        int cycles;
        pick   = $urandom_range(0, 99);
        cycles = 0;
        if (sender_idles) begin
            if (pick >= 92) begin
                cycles = $urandom_range(10, 60);
            end else if (pick >= 55) begin
                cycles = $urandom_range(1, 3);
            end
        end
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every report has come back, then waits for the block
    // to settle so that it is idle.
    task automatic drain();
        i_valid <= 1'b0;
        while (status_board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        status_board.set_register(index, data);
    endtask

    task automatic load_settings(logic [CFG_W-1:0] off_lo, logic [CFG_W-1:0] off_hi,
                                 logic [CFG_W-1:0] set_lo, logic [CFG_W-1:0] set_hi,
                                 logic [CFG_W-1:0] prio, logic [CFG_W-1:0] enable);
        write_register(CFG_OFF_LO, off_lo);
        write_register(CFG_OFF_HI, off_hi);
        write_register(CFG_SET_LO, set_lo);
        write_register(CFG_SET_HI, set_hi);
        write_register(CFG_PRIO, prio);
        write_register(CFG_ENABLE, enable);
        i_cfg_we <= 1'b0;
    endtask

    // Limits lean toward small values so that timeouts and settling both happen
    // at the pace the stimulus advances the tick.
    function automatic logic [CFG_W-1:0] random_limit_word();
        logic [CFG_W-1:0] word;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0:       word[k * LIMIT_W +: LIMIT_W] = '0;
                1:       word[k * LIMIT_W +: LIMIT_W] = '1;
                2, 3:    word[k * LIMIT_W +: LIMIT_W] = LIMIT_W'($urandom);
                default: word[k * LIMIT_W +: LIMIT_W] = LIMIT_W'($urandom_range(1, 200));
            endcase
        end
        return word;
    endfunction

    initial begin : stimulus
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] now;
        logic [CFG_W-1:0]  enable_word;
        logic              cmd;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: every device is disabled and reports its reset state.
        send_item(CMD_SCAN, 3'd0, 32'h0000_0000, 1'b0);
        send_item(CMD_RECEIVE, 3'd7, 32'hFFFF_FFFF, 1'b1);
        random_gap();
        send_item(CMD_SCAN, 3'd7, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Spare indexes first, then a known map: timeouts of 50 except device 7 at 0,
        // settling of 10 except device 7 at the maximum, priority ties on devices 1-3
        // and 5/7, and zero priority on devices 0 and 4.
        write_register(CFG_SPARE_A, '1);
        write_register(CFG_SPARE_B, '1);
        load_settings(64'h0032_0032_0032_0032, 64'h0000_0032_0032_0032,
                      64'h000A_000A_000A_000A, 64'hFFFF_000A_000A_000A,
                      64'h0000_0000_F4F0_3330, 64'h0000_0000_0000_00FF);

        send_item(CMD_RECEIVE, 3'd0, 32'd1000, 1'b0);
        send_item(CMD_RECEIVE, 3'd1, 32'd1000, 1'b1);
        // Device 2 stamps just below the wrap point.
        send_item(CMD_RECEIVE, 3'd2, 32'hFFFF_FFF0, 1'b0);
        send_item(CMD_RECEIVE, 3'd3, 32'd1000, 1'b0);
        random_gap();
        // Devices 0 and 3 settle, device 1 has bad data, the rest are already in
        // error and go offline without a new stamp.
        send_item(CMD_SCAN, 3'd0, 32'd1005, 1'b0);
        send_item(CMD_SCAN, 3'd0, 32'd1020, 1'b0);
        // Healthy devices 0 and 3 drop out here and get a fresh offline stamp.
        send_item(CMD_SCAN, 3'd0, 32'd1080, 1'b0);
        send_item(CMD_RECEIVE, 3'd0, 32'd1090, 1'b0);
        send_item(CMD_RECEIVE, 3'd0, 32'd1095, 1'b0);
        random_gap();
        send_item(CMD_SCAN, 3'd0, 32'd1100, 1'b0);
        // The newest stamp of device 2 wraps below the previous one: no interval refresh.
        send_item(CMD_RECEIVE, 3'd2, 32'h0000_0010, 1'b0);
        send_item(CMD_SCAN, 3'd0, 32'h0000_0030, 1'b0);
        // Device 7 with a zero timeout: silent for zero ticks is fine, one tick is not.
        send_item(CMD_RECEIVE, 3'd7, 32'h0000_0030, 1'b0);
        send_item(CMD_SCAN, 3'd0, 32'h0000_0030, 1'b0);
        send_item(CMD_SCAN, 3'd0, 32'h0000_0031, 1'b1);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            sender_idles = (phase % 3 != 1);
            stall_quiet  = (phase % 3 == 2);
            if (phase == 0) begin
                load_settings('1, '1, '1, '1, '1, '1);
            end else if (phase == 1) begin
                // Everything times out at once and nobody has any priority.
                load_settings('0, '0, '0, '0, '0, 64'h0000_0000_0000_00FF);
            end else begin
                enable_word = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 1) begin
                    enable_word[DEVICES-1:0] = '1;
                end
                load_settings(random_limit_word(), random_limit_word(),
                              random_limit_word(), random_limit_word(),
                              {$urandom, $urandom}, enable_word);
            end
            tick = (phase == 3) ? 32'hFFFF_FF00 : $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The tick mostly crawls forward; sometimes it leaps, and a few items
                // carry an unrelated tick as noise.
                if ($urandom_range(0, 99) < 4) begin
                    now = $urandom;
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        tick = tick + $urandom_range(31, 400);
                    end else begin
                        tick = tick + $urandom_range(0, 30);
                    end
                    now = tick;
                end
                cmd = ($urandom_range(0, 99) < 30) ? CMD_SCAN : CMD_RECEIVE;
                send_item(cmd, IDX_W'($urandom_range(0, DEVICES - 1)), now,
                          ($urandom_range(0, 4) == 0));
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end else begin
                    random_gap();
                end
            end
            drain();
        end

        i_valid <= 1'b0;
        while (status_board.outstanding() != 0) @(posedge i_clk);
        repeat (FINAL_CYCLES) @(posedge i_clk);
        if (status_board.failures == 0 && status_board.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/llw_pkg.sv
sv/llw_ctrl.sv
sv/llw_dp.sv
sv/link_loss_watchdog_monitor.sv
tb/sv/testbench.sv
